>>> hdl/stsc_pkg.sv
// Package for the source token scanner: payload structs, scan modes, codes
// and character class helpers. No dependencies.
package stsc_pkg;

    localparam int INT_BITS  = 32;
    localparam int POS_BITS  = 16;
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int CNT_W     = $clog2(MAX_RES + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // event codes
    localparam logic [1:0] EV_TEXT = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    // token kinds
    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_NEWLINE = 5'd1;
    localparam logic [4:0] K_NONE    = 5'd0;
    localparam logic [4:0] K_STRING  = 5'd13;
    localparam logic [4:0] K_ASSIGN  = 5'd14;
    localparam logic [4:0] K_OPER    = 5'd15;
    localparam logic [4:0] K_INT     = 5'd16;
    localparam logic [4:0] K_IDENT   = 5'd17;
    localparam logic [4:0] K_KEYWORD = 5'd18;

    // error codes
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_ESC     = 3'd1;
    localparam logic [2:0] E_UNTERM  = 3'd2;
    localparam logic [2:0] E_COLON   = 3'd3;
    localparam logic [2:0] E_UNKNOWN = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef enum logic [3:0] {
        M_IDLE,
        M_STR,
        M_ESC,
        M_COLON,
        M_EQ,
        M_MINUS,
        M_OPRUN,
        M_INT,
        M_IDENT
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [7:0]         text_byte;
        logic [4:0]         token_kind;
        logic signed [31:0] tok_value;
        logic [15:0]        start_line;
        logic [15:0]        start_col;
        logic [2:0]         error_code;
        logic               last;
    } t_out;

    typedef t_out [MAX_RES-1:0] t_res_list;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c == 8'h21 || c == 8'h40 || c == 8'h2C || c == 8'h26 || c == 8'h7C ||
               c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h25;
    endfunction

    // kind of a single-character punctuation token, K_NONE if not one
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h28:   k = 5'd2;
            8'h29:   k = 5'd3;
            8'h7B:   k = 5'd4;
            8'h7D:   k = 5'd5;
            8'h5B:   k = 5'd6;
            8'h5D:   k = 5'd7;
            8'h3C:   k = 5'd8;
            8'h3E:   k = 5'd9;
            8'h2E:   k = 5'd10;
            8'h5E:   k = 5'd11;
            8'h7C:   k = 5'd12;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic t_out mk_text(input logic [7:0] c);
        t_out r;
        r = '0;
        r.event_res = EV_TEXT;
        r.text_byte = c;
        return r;
    endfunction

    function automatic t_out mk_end(input logic [4:0] kind, input logic signed [31:0] val,
                                    input logic [POS_BITS-1:0] ln,
                                    input logic [POS_BITS-1:0] cl);
        t_out r;
        r = '0;
        r.event_res  = EV_END;
        r.token_kind = kind;
        r.tok_value  = val;
        r.start_line = 16'(ln);
        r.start_col  = 16'(cl);
        return r;
    endfunction

    function automatic t_out mk_err(input logic [2:0] code, input logic [POS_BITS-1:0] ln,
                                    input logic [POS_BITS-1:0] cl);
        t_out r;
        r = '0;
        r.event_res  = EV_ERR;
        r.error_code = code;
        r.start_line = 16'(ln);
        r.start_col  = 16'(cl);
        return r;
    endfunction

endpackage

>>> hdl/stsc_core.sv
// Scanner state and single-pass step logic: one character in, up to
// MAX_RES results out. Depends on stsc_pkg.
module stsc_core
    import stsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  t_in               i_item,
    output t_res_list         o_res,
    output logic [CNT_W-1:0]  o_cnt
);

    t_mode                r_mode, n_mode;
    logic [INT_BITS-1:0]  r_acc, n_acc;
    logic                 r_neg, n_neg;
    logic [POS_BITS-1:0]  r_line, n_line, r_col, n_col;
    logic [POS_BITS-1:0]  r_tline, n_tline, r_tcol, n_tcol;
    logic                 r_halt, n_halt;

    t_res_list            res;
    logic [CNT_W-1:0]     cnt;
    logic                 consumed;
    logic [POS_BITS-1:0]  ln, cl;
    logic signed [INT_BITS-1:0] int_s;
    logic signed [31:0]   int_val;
    logic [7:0]           c;
    logic [INT_BITS-1:0]  digit, acc10;
    logic [4:0]           pk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_line  <= POS_BITS'(1);
            r_col   <= '0;
            r_tline <= POS_BITS'(1);
            r_tcol  <= '0;
            r_halt  <= 1'b0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_halt  <= n_halt;
        end
    end

    always_comb begin
        c       = i_item.ch;
        digit   = INT_BITS'(c - CH_ZERO);
        acc10   = {r_acc[INT_BITS-4:0], 3'b000} + {r_acc[INT_BITS-2:0], 1'b0} + digit;
        pk      = punct_kind(c);
        int_s   = r_neg ? -r_acc : r_acc;
        int_val = 32'(int_s);

        n_mode   = r_mode;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_line   = r_line;
        n_col    = r_col;
        n_tline  = r_tline;
        n_tcol   = r_tcol;
        n_halt   = r_halt;
        res      = '0;
        cnt      = '0;
        consumed = 1'b0;
        ln       = r_line;
        cl       = r_col;

        if (i_item.op == OP_EOF) begin
            if (!r_halt) begin
                unique case (r_mode)
                    M_STR: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_UNTERM, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_ESC: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_ESC, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_COLON: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_COLON, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_EQ: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_ASSIGN, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_MINUS, M_OPRUN: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_OPER, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_INT: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_INT, int_val, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    M_IDENT: begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_IDENT, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end
                    default: ;
                endcase
            end
            res[cnt[RES_IDX_W-1:0]] = mk_end(K_EOF, '0, r_line, r_col);
            cnt = cnt + CNT_W'(1);
            n_mode  = M_IDLE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_line  = POS_BITS'(1);
            n_col   = '0;
            n_tline = POS_BITS'(1);
            n_tcol  = '0;
            n_halt  = 1'b0;
        end else if (!r_halt) begin
            if (c == CH_NL) begin
                if (r_line != POS_MAX) n_line = r_line + POS_BITS'(1);
                n_col = '0;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_BITS'(1);
            end

            // continue the pending token
            consumed = 1'b1;
            unique case (r_mode)
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_STRING, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else if (c == CH_BSL) begin
                        n_mode = M_ESC;
                    end else if (c == CH_NUL) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_UNTERM, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                    end
                end
                M_ESC: begin
                    if (c == CH_N || c == CH_T) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text((c == CH_N) ? CH_NL : CH_TAB);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_STR;
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_ESC, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_COLON: begin
                    if (c == CH_EQ) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_ASSIGN, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_err(E_COLON, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_halt = 1'b1;
                    end
                    n_mode = M_IDLE;
                end
                M_EQ: begin
                    if (c == CH_EQ) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_OPER, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_ASSIGN, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        consumed = 1'b0;
                    end
                    n_mode = M_IDLE;
                end
                M_MINUS: begin
                    if (is_digit(c)) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        n_acc  = digit;
                        n_mode = M_INT;
                    end else if (is_opchar(c) || c == CH_EQ) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_OPRUN;
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_OPER, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                        consumed = 1'b0;
                    end
                end
                M_OPRUN: begin
                    if (is_opchar(c) || c == CH_EQ) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_OPER, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                        consumed = 1'b0;
                    end
                end
                M_INT: begin
                    if (is_digit(c)) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        n_acc = acc10;
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_INT, int_val, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                        consumed = 1'b0;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                    end else if (c == CH_COLON) begin
                        res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                        cnt = cnt + CNT_W'(1);
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_KEYWORD, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[RES_IDX_W-1:0]] = mk_end(K_IDENT, '0, r_tline, r_tcol);
                        cnt = cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                        consumed = 1'b0;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    consumed = 1'b0;
                end
            endcase

            // start a new token with this character
            if (!consumed) begin
                n_tline = ln;
                n_tcol  = cl;
                n_mode  = M_IDLE;
                priority if (c == CH_SPACE) begin
                    n_mode = M_IDLE;
                end else if (c == CH_NL) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    res[cnt[RES_IDX_W-1:0]] = mk_end(K_NEWLINE, '0, ln, cl);
                    cnt = cnt + CNT_W'(1);
                end else if (pk != K_NONE) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    res[cnt[RES_IDX_W-1:0]] = mk_end(pk, '0, ln, cl);
                    cnt = cnt + CNT_W'(1);
                end else if (c == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (c == CH_COLON) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_mode = M_COLON;
                end else if (c == CH_EQ) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_mode = M_EQ;
                end else if (c == CH_MINUS) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_acc  = '0;
                    n_neg  = 1'b1;
                    n_mode = M_MINUS;
                end else if (is_opchar(c)) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_mode = M_OPRUN;
                end else if (is_digit(c)) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_acc  = digit;
                    n_neg  = 1'b0;
                    n_mode = M_INT;
                end else if (is_alpha(c)) begin
                    res[cnt[RES_IDX_W-1:0]] = mk_text(c);
                    cnt = cnt + CNT_W'(1);
                    n_mode = M_IDENT;
                end else begin
                    res[cnt[RES_IDX_W-1:0]] = mk_err(E_UNKNOWN, ln, cl);
                    cnt = cnt + CNT_W'(1);
                    n_halt = 1'b1;
                end
            end
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

endmodule

>>> hdl/stsc_outbuf.sv
// Result buffer: holds the results of one character and sends them one
// transfer per cycle while not stalled, marking the final one. Depends on stsc_pkg.
module stsc_outbuf
    import stsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_res_list        i_res,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic             i_stall,
    output logic             o_valid,
    output t_out             o_data,
    output logic             o_free
);

    t_res_list              r_mem;
    logic [CNT_W-1:0]       r_left;
    logic [RES_IDX_W-1:0]   r_idx;
    logic                   pop;

    assign o_valid = r_left != '0;
    assign pop     = o_valid && !i_stall;
    assign o_free  = (r_left == '0) || (r_left == CNT_W'(1) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_cnt;
            r_idx  <= '0;
        end else if (pop) begin
            r_left <= r_left - CNT_W'(1);
            r_idx  <= r_idx + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mem <= i_res;
        end
    end

    always_comb begin
        o_data      = r_mem[r_idx];
        o_data.last = (r_left == CNT_W'(1));
    end

endmodule

>>> hdl/source_token_scanner.sv
// Top level of the source token scanner: input register, scanner core and
// result buffer. Depends on stsc_pkg, stsc_core, stsc_outbuf.
//
// Input channel: one transfer per source byte (op 0) or end of input (op 1).
// Output channel: one transfer per result; each byte gives zero to three
// results, end of input one or two, and the last of them has last set.
// A byte's first result passes the input register and then the result
// buffer register before it is offered on the output channel.
// Throughput: one input transfer per cycle while each byte gives at most
// one result and the receiver does not stall; a byte with more results
// holds the input while the single result port of the output buffer sends them.
// While results wait in the buffer, the input register holds the next byte that has results.
// Reset (synchronous, active low) clears the scanner to line 1, column 0
// and empties both stages. When the receiver stalls, the current result
// holds, the input register fills and the stall reaches the sender after one item.
module source_token_scanner
    import stsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic              r_a_vld;
    t_in               r_a_item;
    t_res_list         core_res;
    logic [CNT_W-1:0]  core_cnt;
    logic              buf_free;
    logic              a_go;
    logic              a_take;

    assign a_go       = r_a_vld && (buf_free || core_cnt == '0);
    assign a_take     = !r_a_vld || a_go;
    assign o_in_stall = !a_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_take) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_a_item <= i_in_data;
        end
    end

    stsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (a_go),
        .i_item  (r_a_item),
        .o_res   (core_res),
        .o_cnt   (core_cnt)
    );

    stsc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (a_go && core_cnt != '0),
        .i_res   (core_res),
        .i_cnt   (core_cnt),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (buf_free)
    );

endmodule
